@@ design/mthw_pkg.sv @@
// Shared types and constants of the multi-thread hang watchdog.
// Depends on nothing; every other design file but the two channel interfaces refers to it by scoped names.
package mthw_pkg;

  // Table geometry and time width
  localparam int SLOTS     = 32;
  localparam int TIME_BITS = 32;
  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W     = $clog2(SLOTS + 1);
  localparam int CMP_W     = (TIME_BITS > 32) ? TIME_BITS : 32;

  // Limits in milliseconds
  localparam logic [31:0] MIN_LIMIT_MS     = 32'd5000;
  localparam logic [31:0] DEFAULT_LIMIT_MS = 32'd25000;
  localparam logic [7:0]  SUSP_MAX         = 8'd255;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam logic [0:0] REG_HANG_LIMIT   = 1'b0;
  localparam logic [0:0] REG_CHECK_ENABLE = 1'b1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  typedef enum logic [2:0] {
    OP_HEARTBEAT = 3'd0,
    OP_REMOVE    = 3'd1,
    OP_SUSPEND   = 3'd2,
    OP_RESUME    = 3'd3,
    OP_QUERY     = 3'd4,
    OP_CHECK     = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SCAN   = 2'd1,
    S_UPDATE = 2'd2,
    S_RESULT = 2'd3
  } fsm_t;

  // One table entry as held in the slot memory
  typedef struct packed {
    logic [31:0] client;
    time_t       last_beat;
    logic [7:0]  suspends;
  } slot_t;

  // Configuration seen by the engine
  typedef struct packed {
    logic [31:0] hang_limit;
    logic        check_enable;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic        hung_valid;
    logic [31:0] hung_id;
    logic        new_hang;
    logic        beating;
    status_t     status;
  } res_t;

endpackage

@@ design/mthw_in_if.sv @@
// Input channel of the hang watchdog: valid/ready plus one operation.
// Depends on nothing.
interface mthw_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] client_id;
  logic [31:0] now;
  logic        inhibit;

  modport source (output valid, op, client_id, now, inhibit, input ready);
  modport sink   (input valid, op, client_id, now, inhibit, output ready);
endinterface

@@ design/mthw_out_if.sv @@
// Result channel of the hang watchdog: valid/ready plus one result.
// Depends on nothing.
interface mthw_out_if;
  logic        valid;
  logic        ready;
  logic        hung_valid;
  logic [31:0] hung_id;
  logic        new_hang;
  logic        beating;
  logic [1:0]  status;

  modport source (output valid, hung_valid, hung_id, new_hang, beating, status, input ready);
  modport sink   (input valid, hung_valid, hung_id, new_hang, beating, status, output ready);
endinterface

@@ design/mthw_cfg.sv @@
// APB-style register file: hang limit and check enable.
// Depends on mthw_pkg.
module mthw_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mthw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  output mthw_pkg::cfg_t               cfg
);

  logic [31:0] hang_limit_r;
  logic        check_enable_r;
  logic        wr_en;
  logic [0:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2:2];
  assign wr_en   = psel && penable && pwrite;

  // Take register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hang_limit_r   <= mthw_pkg::DEFAULT_LIMIT_MS;
      check_enable_r <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        mthw_pkg::REG_HANG_LIMIT:   hang_limit_r   <= pwdata;
        mthw_pkg::REG_CHECK_ENABLE: check_enable_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (reg_sel)
      mthw_pkg::REG_HANG_LIMIT:   prdata = hang_limit_r;
      mthw_pkg::REG_CHECK_ENABLE: prdata = {31'd0, check_enable_r};
      default:                    prdata = '0;
    endcase
  end

  assign cfg.hang_limit   = hang_limit_r;
  assign cfg.check_enable = check_enable_r;

endmodule

@@ design/mthw_slot_ram.sv @@
// Slot table memory: one write port, one read port, registered read data.
// Depends on mthw_pkg.
module mthw_slot_ram (
  input  logic                  clk,
  input  logic                  wr_en,
  input  mthw_pkg::idx_t        wr_addr,
  input  mthw_pkg::slot_t       wr_data,
  input  mthw_pkg::idx_t        rd_addr,
  output mthw_pkg::slot_t       rd_data
);

  mthw_pkg::slot_t mem [mthw_pkg::SLOTS];
  mthw_pkg::slot_t rd_data_r;

  // Write entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read entry into the registered read data
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/mthw_engine.sv @@
// Operation engine: scans the slot memory, then writes back one entry and
// registers the result. Holds the slot used bits and the hang flag.
// Depends on mthw_pkg, mthw_in_if, mthw_out_if and mthw_slot_ram.
module mthw_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  mthw_pkg::cfg_t  cfg,
  mthw_in_if.sink         in_chan,
  mthw_out_if.source      out_chan
);

  mthw_pkg::fsm_t   state_r, state_nxt;

  // Latched operation
  mthw_pkg::op_t    op_r;
  logic [31:0]      id_r;
  mthw_pkg::time_t  now_r;
  logic [31:0]      lim_r;
  logic             chk_run_r;

  // Scan bookkeeping
  mthw_pkg::cnt_t   rd_cnt_r;
  logic             dv_r;
  mthw_pkg::idx_t   ev_idx_r;
  logic             found_r;
  mthw_pkg::idx_t   found_idx_r;
  mthw_pkg::slot_t  found_ent_r;
  logic             free_r;
  mthw_pkg::idx_t   free_idx_r;

  // Table state outside the memory
  logic [mthw_pkg::SLOTS-1:0] used_r, used_nxt;
  logic             in_hang_r, in_hang_nxt;

  // Output register and the result pending behind it
  mthw_pkg::res_t   out_r, res_r, res_nxt;
  logic             out_valid_r;

  // Control
  logic             in_xfer;
  logic             rd_issue;
  logic             scan_done;
  logic             do_update;
  logic             load_out;
  logic [31:0]      lim_eff;

  // Memory ports
  logic             wr_en;
  mthw_pkg::idx_t   wr_addr;
  mthw_pkg::slot_t  wr_data;
  mthw_pkg::idx_t   rd_addr;
  mthw_pkg::slot_t  rd_data;

  // Evaluation of the entry read last cycle
  logic             ev_used;
  mthw_pkg::time_t  elapsed;
  logic             hit;

  mthw_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Floor a nonzero limit at the minimum
  assign lim_eff = (cfg.hang_limit != 32'd0 && cfg.hang_limit < mthw_pkg::MIN_LIMIT_MS)
                   ? mthw_pkg::MIN_LIMIT_MS : cfg.hang_limit;

  assign scan_done = (rd_cnt_r == mthw_pkg::cnt_t'(mthw_pkg::SLOTS)) && dv_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mthw_pkg::S_IDLE:   if (in_chan.valid) state_nxt = mthw_pkg::S_SCAN;
      mthw_pkg::S_SCAN:   if (scan_done) state_nxt = mthw_pkg::S_UPDATE;
      mthw_pkg::S_UPDATE: state_nxt = mthw_pkg::S_RESULT;
      mthw_pkg::S_RESULT: if (!out_valid_r || out_chan.ready) state_nxt = mthw_pkg::S_IDLE;
      default:            state_nxt = mthw_pkg::S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_chan.ready = 1'b0;
    rd_issue      = 1'b0;
    do_update     = 1'b0;
    load_out      = 1'b0;
    case (state_r)
      mthw_pkg::S_IDLE:   in_chan.ready = 1'b1;
      mthw_pkg::S_SCAN:   rd_issue = (rd_cnt_r != mthw_pkg::cnt_t'(mthw_pkg::SLOTS));
      mthw_pkg::S_UPDATE: do_update = 1'b1;
      mthw_pkg::S_RESULT: load_out = !out_valid_r || out_chan.ready;
      default: ;
    endcase
  end

  assign in_xfer = in_chan.valid && in_chan.ready;
  assign rd_addr = rd_cnt_r[mthw_pkg::IDX_W-1:0];

  // Match test on the entry returned by the memory
  assign ev_used = used_r[ev_idx_r];
  assign elapsed = now_r - rd_data.last_beat;
  always_comb begin
    if (op_r == mthw_pkg::OP_CHECK) begin
      hit = chk_run_r && ev_used && (rd_data.suspends == 8'd0) &&
            (mthw_pkg::CMP_W'(elapsed) > mthw_pkg::CMP_W'(lim_r));
    end else begin
      hit = ev_used && (rd_data.client == id_r);
    end
  end

  // Write-back and result of the found entry
  always_comb begin
    wr_en       = 1'b0;
    wr_addr     = found_idx_r;
    wr_data     = found_ent_r;
    used_nxt    = used_r;
    in_hang_nxt = in_hang_r;
    res_nxt     = '0;
    res_nxt.status = mthw_pkg::ST_OK;
    case (op_r)
      mthw_pkg::OP_HEARTBEAT: begin
        if (found_r) begin
          wr_en             = 1'b1;
          wr_data.last_beat = now_r;
        end else if (free_r) begin
          wr_en             = 1'b1;
          wr_addr           = free_idx_r;
          wr_data.client    = id_r;
          wr_data.last_beat = now_r;
          wr_data.suspends  = 8'd0;
          used_nxt[free_idx_r] = 1'b1;
        end else begin
          res_nxt.status = mthw_pkg::ST_FULL;
        end
      end
      mthw_pkg::OP_REMOVE: begin
        if (found_r) used_nxt[found_idx_r] = 1'b0;
        else         res_nxt.status = mthw_pkg::ST_NOT_FOUND;
      end
      mthw_pkg::OP_SUSPEND: begin
        if (!found_r) begin
          res_nxt.status = mthw_pkg::ST_NOT_FOUND;
        end else if (found_ent_r.suspends != mthw_pkg::SUSP_MAX) begin
          wr_en            = 1'b1;
          wr_data.suspends = found_ent_r.suspends + 8'd1;
        end
      end
      mthw_pkg::OP_RESUME: begin
        if (!found_r) begin
          res_nxt.status = mthw_pkg::ST_NOT_FOUND;
        end else if (found_ent_r.suspends == 8'd0) begin
          res_nxt.status = mthw_pkg::ST_UNDERFLOW;
        end else begin
          wr_en            = 1'b1;
          wr_data.suspends = found_ent_r.suspends - 8'd1;
          // restamp when the last suspend is released
          if (found_ent_r.suspends == 8'd1) wr_data.last_beat = now_r;
        end
      end
      mthw_pkg::OP_QUERY: begin
        if (found_r) res_nxt.beating = (found_ent_r.suspends == 8'd0);
        else         res_nxt.status = mthw_pkg::ST_NOT_FOUND;
      end
      mthw_pkg::OP_CHECK: begin
        if (found_r) begin
          wr_en              = 1'b1;
          wr_data.last_beat  = now_r;
          res_nxt.hung_valid = 1'b1;
          res_nxt.hung_id    = found_ent_r.client;
        end
        res_nxt.new_hang = found_r && !in_hang_r;
        in_hang_nxt      = found_r;
      end
      default: ;
    endcase
    wr_en = wr_en && do_update;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mthw_pkg::S_IDLE;
      used_r      <= '0;
      in_hang_r   <= 1'b0;
      out_valid_r <= 1'b0;
      dv_r        <= 1'b0;
      rd_cnt_r    <= '0;
      found_r     <= 1'b0;
      free_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dv_r    <= rd_issue;
      // start a scan
      if (in_xfer) begin
        rd_cnt_r <= '0;
        found_r  <= 1'b0;
        free_r   <= 1'b0;
      end else if (rd_issue) begin
        rd_cnt_r <= rd_cnt_r + mthw_pkg::cnt_t'(1);
      end
      // keep the first match and the first free slot
      if (dv_r) begin
        if (hit && !found_r) found_r <= 1'b1;
        if (!ev_used && !free_r) free_r <= 1'b1;
      end
      if (do_update) begin
        used_r    <= used_nxt;
        in_hang_r <= in_hang_nxt;
      end
      if (load_out) out_valid_r <= 1'b1;
      else if (out_chan.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r      <= mthw_pkg::op_t'(in_chan.op);
      id_r      <= in_chan.client_id;
      now_r     <= mthw_pkg::TIME_BITS'(in_chan.now);
      lim_r     <= lim_eff;
      chk_run_r <= cfg.check_enable && (lim_eff != 32'd0) && !in_chan.inhibit;
    end
    if (rd_issue) ev_idx_r <= rd_addr;
    if (dv_r && hit && !found_r) begin
      found_idx_r <= ev_idx_r;
      found_ent_r <= rd_data;
    end
    if (dv_r && !ev_used && !free_r) free_idx_r <= ev_idx_r;
    // hold the result until the output register is free
    if (do_update) res_r <= res_nxt;
    if (load_out)  out_r <= res_r;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.hung_valid = out_r.hung_valid;
  assign out_chan.hung_id    = out_r.hung_id;
  assign out_chan.new_hang   = out_r.new_hang;
  assign out_chan.beating    = out_r.beating;
  assign out_chan.status     = out_r.status;

  // A found slot was in use when the scan saw it
  a_found_used: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mthw_pkg::S_UPDATE && found_r) |-> used_r[found_idx_r])
    else $error("found slot is not in use");

  // A new hang is always a reported hang
  a_new_hang: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_r.new_hang || out_r.hung_valid))
    else $error("new_hang without hung_valid");

  // The read counter never runs past the table
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    rd_cnt_r <= mthw_pkg::cnt_t'(mthw_pkg::SLOTS))
    else $error("scan counter out of range");

  // The memory is written only in the update cycle
  a_wr_update: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> state_r == mthw_pkg::S_UPDATE)
    else $error("slot write outside update");

  // Hang flag changes only on a check
  a_hang_check: assert property (@(posedge clk) disable iff (!rst_n)
    (in_hang_r != $past(in_hang_r)) |-> $past(do_update && op_r == mthw_pkg::OP_CHECK))
    else $error("hang flag changed outside a check");

endmodule

@@ design/multi_thread_hang_watchdog.sv @@
// Top level of the multi-thread hang watchdog.
// Depends on mthw_pkg, mthw_in_if, mthw_out_if, mthw_cfg and mthw_engine.
//
// Usage:
//   in_chan carries one operation per transfer: op, client_id, now, inhibit.
//   out_chan returns exactly one result per operation, in order.
//   The APB-style port holds hang_limit (address 0) and check_enable
//   (address 4); write them only while no operation is in flight.
// Operation flow:
//   Each operation passes through the states idle, which takes its transfer,
//   scan, which reads the slot memory one entry per cycle and checks each
//   entry as its read data returns, write-back, and result, which loads the
//   output register. The next transfer is taken only back in idle, so a new
//   operation is not taken before the last one has loaded its result.
// Reset:
//   rst_n is synchronous, active low. It empties the table (all slots free),
//   clears the hang flag, sets hang_limit to 25000 and check_enable to 0.
// Stall:
//   A finished result sits in the output register; the next operation is
//   still taken and scanned, and waits for the register to drain.
module multi_thread_hang_watchdog (
  input  logic                         clk,
  input  logic                         rst_n,
  mthw_in_if.sink                      in_chan,
  mthw_out_if.source                   out_chan,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mthw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  mthw_pkg::cfg_t cfg;

  // Configuration registers
  mthw_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Scan and write-back engine with the slot memory
  mthw_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
